// ===== hw/rtl/sfc_pkg.sv =====
package sfc_pkg;

    // Frame layout: eight data bytes, then the CRC low and high bytes.
    localparam int FRAME_DATA_BYTES = 8;
    localparam int FRAME_BYTES      = 10;
    localparam int IDX_W            = $clog2(FRAME_BYTES);

    // CRC-16/MODBUS constants, reflected form.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    typedef logic [IDX_W-1:0] byte_idx_t;

    localparam byte_idx_t CRC_IDX  = byte_idx_t'(FRAME_DATA_BYTES);
    localparam byte_idx_t LAST_IDX = byte_idx_t'(FRAME_BYTES - 1);

    // One sample set as raw 16-bit patterns.
    typedef struct packed {
        logic [15:0] ch3;
        logic [15:0] ch2;
        logic [15:0] ch1;
        logic [15:0] ch0;
    } sample_set_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Fold one byte into the running CRC, least significant bit first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/sfc_front.sv =====
module sfc_front
    import sfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [15:0]  channel_zero,
    input  logic [15:0]  channel_one,
    input  logic [15:0]  channel_two,
    input  logic [15:0]  channel_three,
    input  q_status_t    q_status,
    output logic         push,
    output sample_set_t  push_entry
);

    logic        hold_valid_reg;
    logic        hold_valid_next;
    sample_set_t hold_data_reg;
    logic        accept;

    // The holding register frees up whenever its request moves into the queue.
    assign push     = hold_valid_reg && !q_status.full;
    assign in_stall = hold_valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;

    assign push_entry = hold_data_reg;

    // Next value of the holding register's valid flag.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Capture the sample set as raw bit patterns.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_data_reg <= '{ch3: channel_three, ch2: channel_two,
                               ch1: channel_one,   ch0: channel_zero};
        end
    end

endmodule

// ===== hw/rtl/sfc_queue.sv =====
module sfc_queue
    import sfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  sample_set_t  push_entry,
    input  logic         pop,
    output sample_set_t  pop_entry,
    output q_status_t    q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sample_set_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);
    assign pop_entry      = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/sfc_back.sv =====
module sfc_back
    import sfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_status_t    q_status,
    input  sample_set_t  pop_entry,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   frame_byte,
    output logic         frame_end
);

    logic        busy_reg;
    logic        busy_next;
    byte_idx_t   idx_reg;
    byte_idx_t   idx_next;
    logic [63:0] data_reg;
    logic [63:0] data_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        out_end_reg;
    logic        out_end_next;
    logic        out_free;
    logic        produce;
    logic        last;
    logic [7:0]  cur_byte;

    // A byte is produced whenever a frame is in progress and the output
    // register is free or being emptied.
    assign out_free = !out_valid_reg || !out_stall;
    assign produce  = busy_reg && out_free;
    assign last     = produce && (idx_reg == LAST_IDX);
    assign pop      = !q_status.empty && (!busy_reg || last);

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign frame_end  = out_end_reg;

    // Select the byte at the current frame position.
    always_comb
    begin
        if (idx_reg < CRC_IDX)
        begin
            cur_byte = data_reg[7:0];
        end
        else if (idx_reg == CRC_IDX)
        begin
            cur_byte = crc_reg[7:0];
        end
        else
        begin
            cur_byte = crc_reg[15:8];
        end
    end

    // Serializer and CRC step: one byte per cycle while a frame is in progress and the output register is free.
    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        data_next      = data_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;

        if (out_free)
        begin
            out_valid_next = produce;
        end

        if (produce)
        begin
            out_byte_next = cur_byte;
            out_end_next  = last;
            idx_next      = idx_reg + 1'b1;
            data_next     = data_reg >> 8;
            if (idx_reg < CRC_IDX)
            begin
                crc_next = crc16_byte(crc_reg, data_reg[7:0]);
            end
        end

        // Load the next sample set as the current frame finishes, or when idle.
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            data_next = pop_entry;
            crc_next  = CRC_INIT;
        end
        else if (last)
        begin
            busy_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        crc_reg      <= crc_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

endmodule

// ===== hw/rtl/scope_frame_crc16_encoder_core.sv =====
// Path: an accepted sample set passes the holding register, the queue memory, the
// frame data register and the output byte register; frame_end marks its last byte.
// Throughput: one byte per cycle while a frame is in progress and out_stall is low,
// set by the output serializer, which folds each data byte into the CRC.
// Reset: rst_n clears the queue, the frame sequencer and the output valid at once.
module scope_frame_crc16_encoder_core
    import sfc_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  channel_zero,
    input  logic signed [15:0]  channel_one,
    input  logic signed [15:0]  channel_two,
    input  logic signed [15:0]  channel_three,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          frame_byte,
    output logic                frame_end
);

    q_status_t   q_status;
    logic        push;
    logic        pop;
    sample_set_t push_entry;
    sample_set_t pop_entry;

    // Front part: takes requests and holds them for the queue.
    sfc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .channel_zero  (channel_zero),
        .channel_one   (channel_one),
        .channel_two   (channel_two),
        .channel_three (channel_three),
        .q_status      (q_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    // Queue between the two parts.
    sfc_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    // Back part: frame serializer with CRC.
    sfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_end  (frame_end)
    );

`ifndef ASSERT_OFF
    // The queue is never full and empty at once.
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    // No write into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("queue written while full");

    // No read from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue read while empty");

    // A taken frame end byte is not followed by another frame end byte.
    a_end_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && frame_end) |=> !(out_valid && frame_end))
        else $error("two frame end bytes in a row");
`endif

endmodule
